/* sv/tfrq_pkg.sv */
// tfrq_pkg: shared types and constants for the timed frame release queue
// no dependencies
`timescale 1ns / 1ps

package tfrq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [15:0] late_frames;
    } t_out_item;

    localparam logic [7:0]  RESET_BYTE   = 8'hFF;
    localparam logic [15:0] LATE_MAX     = 16'hFFFF;
    localparam int          PREFIX_BYTES = 4;

endpackage

/* sv/tfrq_byte_ram.sv */
// tfrq_byte_ram: byte store with one write port and one registered read port
// forwards a same-cycle write to the read data; uses no package
`timescale 1ns / 1ps

module tfrq_byte_ram #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/timed_frame_release_queue_top.sv */
// timed_frame_release_queue_top: byte fifo with timed release of framed payloads
// depends on tfrq_pkg and tfrq_byte_ram
// push, start and stop act from idle; the stop result is registered for the following cycle
// a tick steps through prefix loads, frame checks and payload bytes until a check fails
// payload bytes pass a hold register and the output register; one per cycle in S_EMIT
// the receiver cannot stall; busy is high for the whole tick sequence
// synchronous active-low reset clears pointers, counters, clock and prefix; store undefined
`timescale 1ns / 1ps

module timed_frame_release_queue_top #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tfrq_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output tfrq_pkg::t_out_item o_item
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [31:0]         r_clock, n_clock;
    logic [7:0]          r_len, n_len;
    logic [23:0]         r_time, n_time;
    logic                r_held, n_held;
    logic [15:0]         r_late, n_late;
    logic                r_running, n_running;
    logic [1:0]          r_load_cnt, n_load_cnt;
    logic [7:0]          r_remain, n_remain;
    logic                r_hold_valid, n_hold_valid;
    logic [7:0]          r_hold_byte, n_hold_byte;
    logic [15:0]         r_hold_late, n_hold_late;
    logic                r_strobe, n_strobe;
    tfrq_pkg::t_out_item r_out, n_out;

    logic                accept;
    logic                wr_en;
    logic [7:0]          head;
    logic [PTR_W-1:0]    rd_ptr_inc;
    logic [PTR_W-1:0]    wr_ptr_inc;

    assign accept = start && (r_state == S_IDLE);
    assign wr_en  = accept && (i_item.opcode == tfrq_pkg::OP_PUSH)
                    && (r_fill < CNT_W'(FIFO_DEPTH));

    assign rd_ptr_inc = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
    assign wr_ptr_inc = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);

    tfrq_byte_ram #(
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (i_item.in_byte),
        .i_rd_addr (n_rd_ptr),
        .o_rd_data (head)
    );

    always_comb begin
        n_state      = r_state;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_fill       = r_fill;
        n_clock      = r_clock;
        n_len        = r_len;
        n_time       = r_time;
        n_held       = r_held;
        n_late       = r_late;
        n_running    = r_running;
        n_load_cnt   = r_load_cnt;
        n_remain     = r_remain;
        n_hold_valid = r_hold_valid;
        n_hold_byte  = r_hold_byte;
        n_hold_late  = r_hold_late;
        n_strobe     = 1'b0;
        n_out        = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.opcode)
                        tfrq_pkg::OP_PUSH: begin
                            if (wr_en) begin
                                n_wr_ptr = wr_ptr_inc;
                                n_fill   = r_fill + CNT_W'(1);
                            end
                        end
                        tfrq_pkg::OP_TICK: begin
                            if (r_running) begin
                                if (!r_held && (r_fill > CNT_W'(tfrq_pkg::PREFIX_BYTES))) begin
                                    n_state    = S_LOAD;
                                    n_load_cnt = '0;
                                end else begin
                                    n_state = S_CHECK;
                                end
                            end
                        end
                        tfrq_pkg::OP_START: begin
                            n_running = 1'b1;
                        end
                        tfrq_pkg::OP_STOP: begin
                            n_running         = 1'b0;
                            n_clock           = '0;
                            n_len             = '0;
                            n_time            = '0;
                            n_held            = 1'b0;
                            n_late            = '0;
                            n_strobe          = 1'b1;
                            n_out.out_byte    = tfrq_pkg::RESET_BYTE;
                            n_out.last        = 1'b1;
                            n_out.late_frames = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_LOAD: begin
                n_rd_ptr   = rd_ptr_inc;
                n_fill     = r_fill - CNT_W'(1);
                n_load_cnt = r_load_cnt + 2'd1;
                unique case (r_load_cnt)
                    2'd0: n_len          = head;
                    2'd1: n_time[23:16]  = head;
                    2'd2: n_time[15:8]   = head;
                    2'd3: begin
                        n_time[7:0] = head;
                        n_held      = 1'b1;
                        n_state     = S_CHECK;
                    end
                    default: begin
                    end
                endcase
            end

            S_CHECK: begin
                if (r_held && ({8'd0, r_time} <= r_clock)
                    && ({{(8 > CNT_W ? 8 - CNT_W : 0){1'b0}}, r_fill} >= r_len)) begin
                    if (({8'd0, r_time} < r_clock) && (r_late != tfrq_pkg::LATE_MAX)) begin
                        n_late = r_late + 16'd1;
                    end
                    if (r_len == 8'd0) begin
                        if (r_fill > CNT_W'(tfrq_pkg::PREFIX_BYTES)) begin
                            n_state    = S_LOAD;
                            n_load_cnt = '0;
                        end else begin
                            n_held = 1'b0;
                        end
                    end else begin
                        n_remain = r_len;
                        n_state  = S_EMIT;
                    end
                end else begin
                    n_clock      = r_clock + 32'd1;
                    n_state      = S_IDLE;
                    n_hold_valid = 1'b0;
                    if (r_hold_valid) begin
                        n_strobe          = 1'b1;
                        n_out.out_byte    = r_hold_byte;
                        n_out.last        = 1'b1;
                        n_out.late_frames = r_hold_late;
                    end
                end
            end

            S_EMIT: begin
                n_rd_ptr     = rd_ptr_inc;
                n_fill       = r_fill - CNT_W'(1);
                n_remain     = r_remain - 8'd1;
                n_hold_valid = 1'b1;
                n_hold_byte  = head;
                n_hold_late  = r_late;
                if (r_hold_valid) begin
                    n_strobe          = 1'b1;
                    n_out.out_byte    = r_hold_byte;
                    n_out.last        = 1'b0;
                    n_out.late_frames = r_hold_late;
                end
                if (r_remain == 8'd1) begin
                    if (r_fill > CNT_W'(tfrq_pkg::PREFIX_BYTES + 1)) begin
                        n_state    = S_LOAD;
                        n_load_cnt = '0;
                    end else begin
                        n_held  = 1'b0;
                        n_state = S_CHECK;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_fill       <= '0;
            r_clock      <= '0;
            r_len        <= '0;
            r_time       <= '0;
            r_held       <= 1'b0;
            r_late       <= '0;
            r_running    <= 1'b0;
            r_load_cnt   <= '0;
            r_remain     <= '0;
            r_hold_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_fill       <= n_fill;
            r_clock      <= n_clock;
            r_len        <= n_len;
            r_time       <= n_time;
            r_held       <= n_held;
            r_late       <= n_late;
            r_running    <= n_running;
            r_load_cnt   <= n_load_cnt;
            r_remain     <= n_remain;
            r_hold_valid <= n_hold_valid;
            r_strobe     <= n_strobe;
        end
        r_hold_byte <= n_hold_byte;
        r_hold_late <= n_hold_late;
        r_out       <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_item   = r_out;

endmodule
